>>> rtl/udpce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package udpce_pkg;

    localparam logic [15:0] MAX_CHECKED_LEN = 16'd1500;
    localparam logic [15:0] HDR_BYTES       = 16'd8;
    localparam logic [18:0] PROTO_UDP       = 19'd17;
    localparam logic [15:0] ECHO_PORT_RST   = 16'd7;
    localparam logic [15:0] CSUM_ALL_ONES   = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ECHO     = 3'd1,
        ST_TOO_LONG = 3'd2,
        ST_BAD_SIZE = 3'd3,
        ST_BAD_HDR  = 3'd4,
        ST_BAD_SUM  = 3'd5
    } t_status;

    // Packet state captured on the last byte of a datagram
    typedef struct packed {
        logic [15:0] count;
        logic [15:0] src_udp_port;
        logic [15:0] dst_udp_port;
        logic [15:0] length;
        logic [15:0] csum_field;
        logic [31:0] acc;
    } t_snap;

    typedef struct packed {
        t_status     status;
        logic [15:0] src_udp_port;
        logic [15:0] dst_udp_port;
        logic [15:0] udp_length;
        logic [15:0] payload_length;
        logic [15:0] reply_checksum;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/udpce_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module udpce_parse (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic [7:0]        i_byte,
    input  wire logic [18:0]       i_ph,
    input  wire logic              i_last,
    output udpce_pkg::t_snap       o_snap
);

    logic [15:0] r_count;
    logic [31:0] r_acc;
    logic [7:0]  r_held;
    logic [15:0] r_src;
    logic [15:0] r_dst;
    logic [15:0] r_len;
    logic [15:0] r_csf;

    logic [15:0] n_count;
    logic [31:0] n_acc;
    logic [7:0]  n_held;
    logic [15:0] n_src;
    logic [15:0] n_dst;
    logic [15:0] n_len;
    logic [15:0] n_csf;

    logic [15:0] word;
    logic [31:0] add_ph;
    logic [31:0] add_len;
    logic [31:0] add_byte;
    logic        byte_in_sum;

    assign word = {r_held, i_byte};

    // Skip the checksum field and anything past the length field
    assign byte_in_sum = (r_count < 16'd6) ||
                         ((r_count >= udpce_pkg::HDR_BYTES) && (r_count < r_len));

    always_comb begin
        add_ph   = (r_count == 16'd0) ? {13'd0, i_ph} : 32'd0;
        add_len  = (r_count == 16'd5) ? {16'd0, word} : 32'd0;
        add_byte = 32'd0;
        if (byte_in_sum) begin
            add_byte = r_count[0] ? {24'd0, i_byte} : {16'd0, i_byte, 8'd0};
        end
        n_acc   = r_acc + add_ph + add_len + add_byte;
        n_count = (r_count == 16'hFFFF) ? r_count : r_count + 16'd1;
        n_held  = r_count[0] ? r_held : i_byte;
        n_src   = (r_count == 16'd1) ? word : r_src;
        n_dst   = (r_count == 16'd3) ? word : r_dst;
        n_len   = (r_count == 16'd5) ? word : r_len;
        n_csf   = (r_count == 16'd7) ? word : r_csf;
    end

    assign o_snap = '{count: n_count, src_udp_port: n_src, dst_udp_port: n_dst,
                      length: n_len, csum_field: n_csf, acc: n_acc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last)) begin
            r_count <= '0;
            r_acc   <= '0;
            r_held  <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_len   <= '0;
            r_csf   <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
            r_acc   <= n_acc;
            r_held  <= n_held;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_len   <= n_len;
            r_csf   <= n_csf;
        end
    end

endmodule

`default_nettype wire

>>> rtl/udpce_verdict.sv
`timescale 1ns / 1ps
`default_nettype none

module udpce_verdict (
    input  wire udpce_pkg::t_snap  i_snap,
    input  wire logic [15:0]       i_echo_port,
    output udpce_pkg::t_result     o_result
);

    logic [16:0] fold1;
    logic [15:0] rsum;
    logic [16:0] chk_raw;
    logic [15:0] chk;
    logic        sum_bad;
    logic        checked;
    logic [15:0] reply;

    // Fold the wide accumulator back to a 16-bit one's-complement sum
    assign fold1   = {1'b0, i_snap.acc[15:0]} + {1'b0, i_snap.acc[31:16]};
    assign rsum    = fold1[15:0] + {15'd0, fold1[16]};
    assign chk_raw = {1'b0, rsum} + {1'b0, i_snap.csum_field};
    assign chk     = chk_raw[15:0] + {15'd0, chk_raw[16]};
    assign sum_bad = (chk != udpce_pkg::CSUM_ALL_ONES);
    assign checked = (i_snap.csum_field != 16'd0) &&
                     (i_snap.length <= udpce_pkg::MAX_CHECKED_LEN);
    assign reply   = (rsum == udpce_pkg::CSUM_ALL_ONES) ? udpce_pkg::CSUM_ALL_ONES : ~rsum;

    always_comb begin
        o_result = '{status: udpce_pkg::ST_BAD_SIZE, src_udp_port: 16'd0,
                     dst_udp_port: 16'd0, udp_length: 16'd0, payload_length: 16'd0,
                     reply_checksum: 16'd0};
        if (i_snap.count >= udpce_pkg::HDR_BYTES) begin
            o_result.src_udp_port = i_snap.src_udp_port;
            o_result.dst_udp_port = i_snap.dst_udp_port;
            o_result.udp_length   = i_snap.length;
            if (i_snap.length < udpce_pkg::HDR_BYTES) begin
                o_result.status = udpce_pkg::ST_BAD_HDR;
            end else begin
                o_result.payload_length = i_snap.length - udpce_pkg::HDR_BYTES;
                if (i_snap.length > i_snap.count) begin
                    o_result.status = udpce_pkg::ST_BAD_SIZE;
                end else if (checked && sum_bad) begin
                    o_result.status = udpce_pkg::ST_BAD_SUM;
                end else if (i_snap.dst_udp_port != i_echo_port) begin
                    o_result.status = udpce_pkg::ST_OK;
                end else if (i_snap.length > udpce_pkg::MAX_CHECKED_LEN) begin
                    o_result.status = udpce_pkg::ST_TOO_LONG;
                end else begin
                    o_result.status         = udpce_pkg::ST_ECHO;
                    o_result.reply_checksum = reply;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/udp_datagram_check_echo.sv
`timescale 1ns / 1ps
`default_nettype none

// UDP receive check with echo reply checksum.
// Input channel: one datagram byte per word (i_in_valid / o_in_stall), header
// first, with the IP addresses sampled on the first byte and i_last_byte on
// the final byte of the packet. Non-final bytes give no output.
// Output channel (o_out_valid / i_out_stall): one verdict word per packet,
// carrying status, ports, length fields and the echo reply checksum.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): sets the echo
// port; write it only while no packet is in flight.
// Throughput: one byte per cycle, set by the 32-bit accumulate of the parse
// stage, until a stalled receiver backs the stages up to the input; the
// one's-complement fold is done once per packet in the verdict stage. Path:
// the last byte loads the input register, then the packet snapshot
// register, then the result register, which holds the valid verdict.
// Reset (synchronous, active low) empties all stages, clears packet state
// and sets the echo port to 7.
// A stalled receiver holds the result register; bubbles in front of it close
// up, and the input stalls only once every stage ahead of a byte is full.

module udp_datagram_check_echo (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [31:0] i_src_ip,
    input  wire logic [31:0] i_dst_ip,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [15:0]      o_src_udp_port,
    output logic [15:0]      o_dst_udp_port,
    output logic [15:0]      o_udp_length,
    output logic [15:0]      o_payload_length,
    output logic [15:0]      o_reply_checksum,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [18:0] r_in_ph;
    logic        r_in_last;
    logic [18:0] n_in_ph;

    // Snapshot and result registers
    logic                 r_snap_valid;
    udpce_pkg::t_snap     r_snap;
    udpce_pkg::t_snap     n_snap;
    logic                 r_out_valid;
    udpce_pkg::t_result   r_out;
    udpce_pkg::t_result   n_out;

    logic [15:0] r_echo_port;

    logic out_free;
    logic snap_free;
    logic parse_fire;
    logic in_ready;
    logic in_take;

    // Stage handshakes: a stage advances when the one after it has room (non-final bytes never wait)
    assign out_free   = !r_out_valid || !i_out_stall;
    assign snap_free  = !r_snap_valid || out_free;
    assign parse_fire = r_in_valid && (!r_in_last || snap_free);
    assign in_ready   = !r_in_valid || parse_fire;
    assign in_take    = i_in_valid && in_ready;
    assign o_in_stall = !in_ready;

    // Pseudo-header terms without the length word, summed on the way in
    assign n_in_ph = {3'b000, i_src_ip[31:16]} + {3'b000, i_src_ip[15:0]}
                   + {3'b000, i_dst_ip[31:16]} + {3'b000, i_dst_ip[15:0]}
                   + udpce_pkg::PROTO_UDP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_ph   <= n_in_ph;
            r_in_last <= i_last_byte;
        end
    end

    udpce_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (parse_fire),
        .i_byte  (r_in_byte),
        .i_ph    (r_in_ph),
        .i_last  (r_in_last),
        .o_snap  (n_snap)
    );

    // Capture the packet state only on the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (snap_free) begin
            r_snap_valid <= parse_fire && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (parse_fire && r_in_last) begin
            r_snap <= n_snap;
        end
    end

    udpce_verdict u_verdict (
        .i_snap      (r_snap),
        .i_echo_port (r_echo_port),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_snap_valid) begin
            r_out <= n_out;
        end
    end

    // Echo port register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_port <= udpce_pkg::ECHO_PORT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_echo_port <= i_cfg_data;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_src_udp_port   = r_out.src_udp_port;
    assign o_dst_udp_port   = r_out.dst_udp_port;
    assign o_udp_length     = r_out.udp_length;
    assign o_payload_length = r_out.payload_length;
    assign o_reply_checksum = r_out.reply_checksum;

    // A new verdict comes only from a captured snapshot
    a_out_from_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_snap_valid))
        else $error("verdict appeared without a packet snapshot");

    // A snapshot is loaded only by a final byte
    a_snap_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_snap_valid) |-> $past(r_in_valid && r_in_last))
        else $error("snapshot loaded without a final byte");

    // Echo replies never carry a zero checksum
    a_echo_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == udpce_pkg::ST_ECHO)) |-> (o_reply_checksum != 16'd0))
        else $error("echo reply with zero checksum");

    // Only echo replies carry a reply checksum
    a_reply_only_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != udpce_pkg::ST_ECHO)) |-> (o_reply_checksum == 16'd0))
        else $error("reply checksum on a non-echo verdict");

endmodule

`default_nettype wire
